// ===== rtl/core/sscr_pkg.sv =====
// Shared types and constants for the shadow stack return checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sscr_pkg;
   localparam int STACK_DEPTH   = 64;
   localparam int MAX_SEARCH    = 4;
   localparam int TABLE_ENTRIES = 16;
   localparam int SP_W   = $clog2(STACK_DEPTH);
   localparam int FILL_W = $clog2(STACK_DEPTH + 1);
   localparam int TI_W   = $clog2(TABLE_ENTRIES);
   localparam int TF_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int SD_W   = $clog2(MAX_SEARCH + 1);

   typedef enum logic [1:0] {
      CMD_CALL = 2'd0, CMD_RET = 2'd1, CMD_READ = 2'd2, CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_PUSHED = 3'd0, ST_DROPPED = 3'd1, ST_MATCHED = 3'd2, ST_MISMATCH = 3'd3,
      ST_TBL_FULL = 3'd4, ST_EMPTY = 3'd5, ST_READ = 3'd6
   } status_type;

   // status in the low bits, entry_valid on top
   typedef struct packed {
      logic        entry_valid;
      logic [63:0] entry_site;
      logic [63:0] expected_return;
      logic [63:0] caller_site;
      logic [31:0] mismatch_count;
      logic [1:0]  match_depth;
      status_type  status;
   } result_type;

   localparam int ST_W = $bits(status_type);
   localparam int RSP_BITS = $bits(result_type);
   localparam int RSP_DATA_BITS = RSP_BITS - ST_W;
   localparam int RSP_W = ((RSP_DATA_BITS + 7) / 8) * 8;
   localparam int REQ_W = 136;
endpackage
`default_nettype wire

// ===== rtl/core/sscr_cmp.sv =====
// Shared 64-bit equality comparator used by the sequencer for stack and table probes.
// Depends on: nothing.
`timescale 1ns / 1ps
`default_nettype none
module sscr_cmp (
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             eq
);
   assign eq = (a == b);
endmodule
`default_nettype wire

// ===== rtl/core/shadow_stack_return_checker.sv =====
// Top level: shadow stack return checker with a sequencer around one shared comparator.
// Depends on: sscr_pkg, sscr_cmp.
//
// Channel | Dir | Handshake         | Payload
// req     | in  | req_tvalid/tready | command (tuser), site, target, entry_index
// rsp     | out | rsp_tvalid/tready | status (tuser), other result fields
// csr     | in  | csr_wen           | search_depth
// Call, empty return and unknown command pass PREP then OUT; read passes PREP, RD, OUT.
// Return: each stack entry probed takes a PREP/STK pass; a miss then probes table
// entries through TOP/TBL passes, then UPD and OUT (an empty table skips TBL).
// Result waits in rsp register; req_tready stays low until it is taken. Reset clears
// fill counts, pointer, table valid bits and search_depth (to 4).
`timescale 1ns / 1ps
`default_nettype none
module shadow_stack_return_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // site_address[63:0], return_target[127:64], entry_index[131:128], zeros
   input  wire logic [sscr_pkg::REQ_W-1:0] req_tdata,
   input  wire logic [1:0]  req_tuser, // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // match_depth[1:0], mismatch_count[33:2], caller_site[97:34], expected_return[161:98],
   // entry_site[225:162], entry_valid[226], zeros
   output logic [sscr_pkg::RSP_W-1:0] rsp_tdata,
   output logic [2:0]       rsp_tuser, // status
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_wdata
);
   import sscr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_STK, S_TOP, S_TBL, S_UPD, S_RD, S_OUT
   } state_type;

   state_type   state_ff;
   logic [2:0]  sdepth_ff;
   cmd_type     cmd_ff;
   logic [63:0] site_ff, tgt_ff;
   logic [TI_W-1:0] idx_ff;
   logic [SP_W-1:0] top_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [TF_W-1:0] tfill_ff;
   logic [TABLE_ENTRIES-1:0] tvalid_ff;
   logic [SD_W-1:0] lim_ff, pos_ff;
   logic [TI_W:0] ti_ff;
   logic [63:0] stk_site_q, stk_ret_q, top_site_ff, top_ret_ff;
   logic [63:0] tk_q, tc_q;
   logic [31:0] tn_q;
   logic [SP_W-1:0] rd_slot;
   logic [TI_W-1:0] trd;
   logic        swe, twe, hit_ff;
   logic [TI_W-1:0] twa, hit_idx_ff;
   logic [63:0] twc;
   logic [31:0] twn;
   result_type  rsp_ff;
   logic [63:0] cmp_a, cmp_b;
   logic        eq;

   logic [63:0] stk_site [STACK_DEPTH];
   logic [63:0] stk_ret  [STACK_DEPTH];
   logic [63:0] tbl_key  [TABLE_ENTRIES];
   logic [63:0] tbl_call [TABLE_ENTRIES];
   logic [31:0] tbl_cnt  [TABLE_ENTRIES];

   sscr_cmp u_cmp (.a(cmp_a), .b(cmp_b), .eq(eq));

   assign req_tready = (state_ff == S_IDLE) && !rsp_tvalid;
   assign rsp_tdata  = RSP_W'(rsp_ff[RSP_BITS-1:ST_W]);
   assign rsp_tuser  = rsp_ff.status;
   assign rd_slot = top_ff - SP_W'(1) - SP_W'(pos_ff);
   assign trd = (state_ff == S_RD) ? idx_ff : ti_ff[TI_W-1:0];

   always_comb begin
      cmp_a = tgt_ff;
      cmp_b = stk_ret_q;
      if (state_ff == S_TBL) begin
         cmp_a = site_ff;
         cmp_b = tk_q;
      end
   end

   always_ff @(posedge clock) begin
      stk_site_q <= stk_site[rd_slot];
      stk_ret_q  <= stk_ret[rd_slot];
      if (swe) begin
         stk_site[top_ff] <= site_ff;
         stk_ret[top_ff]  <= tgt_ff;
      end
   end

   always_ff @(posedge clock) begin
      tk_q <= tbl_key[trd];
      tc_q <= tbl_call[trd];
      tn_q <= tbl_cnt[trd];
      if (twe) begin
         tbl_key[twa]  <= site_ff;
         tbl_call[twa] <= twc;
         tbl_cnt[twa]  <= twn;
      end
   end

   always_comb begin
      swe = (state_ff == S_PREP) && (cmd_ff == CMD_CALL);
      twe = (state_ff == S_UPD) && (hit_ff || (32'(tfill_ff) < TABLE_ENTRIES));
      twa = hit_ff ? hit_idx_ff : tfill_ff[TI_W-1:0];
      twc = hit_ff ? tc_q : top_site_ff;
      twn = hit_ff ? ((tn_q == '1) ? tn_q : tn_q + 32'd1) : 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; sdepth_ff <= 3'd4; fill_ff <= '0; top_ff <= '0;
         tfill_ff <= '0; tvalid_ff <= '0; rsp_tvalid <= 1'b0;
      end else begin
         if (csr_wen) sdepth_ff <= csr_wdata;
         if (rsp_tvalid && rsp_tready) rsp_tvalid <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               cmd_ff  <= cmd_type'(req_tuser);
               site_ff <= req_tdata[63:0];
               tgt_ff  <= req_tdata[127:64];
               idx_ff  <= req_tdata[128 +: TI_W];
               pos_ff  <= '0;
               ti_ff   <= '0;
               hit_ff  <= 1'b0;
               state_ff <= S_PREP;
            end
            S_PREP: begin
               rsp_ff <= '0;
               unique case (cmd_ff)
                  CMD_CALL: begin
                     top_ff <= top_ff + SP_W'(1);
                     if (32'(fill_ff) >= STACK_DEPTH) rsp_ff.status <= ST_DROPPED;
                     else begin
                        fill_ff <= fill_ff + FILL_W'(1);
                        rsp_ff.status <= ST_PUSHED;
                     end
                     state_ff <= S_OUT;
                  end
                  CMD_RET: begin
                     if (fill_ff == '0) begin
                        rsp_ff.status <= ST_EMPTY;
                        state_ff <= S_OUT;
                     end else begin
                        logic [SD_W:0] d;
                        d = (sdepth_ff == 3'd0) ? (SD_W+1)'(1) : (SD_W+1)'(sdepth_ff);
                        if (32'(d) > MAX_SEARCH) d = (SD_W+1)'(MAX_SEARCH);
                        if (32'(d) > 32'(fill_ff)) d = (SD_W+1)'(fill_ff);
                        lim_ff <= SD_W'(d);
                        state_ff <= S_STK;
                     end
                  end
                  CMD_READ: state_ff <= S_RD;
                  default: begin
                     rsp_ff.status <= ST_READ;
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_STK: begin
               // stk_ret_q holds entry at pos_ff
               if (pos_ff == '0) begin
                  top_site_ff <= stk_site_q;
                  top_ret_ff  <= stk_ret_q;
               end
               if (eq) begin
                  top_ff  <= top_ff - SP_W'(pos_ff) - SP_W'(1);
                  fill_ff <= fill_ff - FILL_W'(pos_ff) - FILL_W'(1);
                  rsp_ff.status <= ST_MATCHED;
                  rsp_ff.match_depth <= pos_ff[1:0];
                  state_ff <= S_OUT;
               end else if (pos_ff + SD_W'(1) == lim_ff) begin
                  state_ff <= S_TOP;
               end else begin
                  // prep again lets the next stack read land before S_STK compares it
                  pos_ff <= pos_ff + SD_W'(1);
                  state_ff <= S_PREP;
               end
            end
            S_TOP: begin
               // table read of entry ti_ff issued; S_TBL compares the registered result
               rsp_ff.expected_return <= top_ret_ff;
               if (tfill_ff == '0) state_ff <= S_UPD;
               else state_ff <= S_TBL;
            end
            S_TBL: begin
               if (tvalid_ff[ti_ff[TI_W-1:0]] && eq) begin
                  hit_ff <= 1'b1;
                  hit_idx_ff <= ti_ff[TI_W-1:0];
                  state_ff <= S_UPD;
               end else if ((TI_W+1)'(ti_ff + 1'b1) >= (TI_W+1)'(tfill_ff)) begin
                  state_ff <= S_UPD;
               end else begin
                  ti_ff <= ti_ff + (TI_W+1)'(1);
                  state_ff <= S_TOP;
               end
            end
            S_UPD: begin
               if (hit_ff) begin
                  rsp_ff.status <= ST_MISMATCH;
                  rsp_ff.mismatch_count <= twn;
                  rsp_ff.caller_site <= tc_q;
               end else if (32'(tfill_ff) < TABLE_ENTRIES) begin
                  tvalid_ff[tfill_ff[TI_W-1:0]] <= 1'b1;
                  tfill_ff <= tfill_ff + TF_W'(1);
                  rsp_ff.status <= ST_MISMATCH;
                  rsp_ff.mismatch_count <= 32'd1;
                  rsp_ff.caller_site <= top_site_ff;
               end else begin
                  rsp_ff.status <= ST_TBL_FULL;
               end
               state_ff <= S_OUT;
            end
            S_RD: begin
               // read data of idx_ff arrives next cycle
               state_ff <= S_OUT;
               cmd_ff <= CMD_NONE;
               rsp_ff.status <= ST_READ;
               hit_ff <= tvalid_ff[idx_ff];
            end
            S_OUT: begin
               if (cmd_ff == CMD_NONE && hit_ff && rsp_ff.status == ST_READ) begin
                  rsp_ff.mismatch_count <= tn_q;
                  rsp_ff.caller_site <= tc_q;
                  rsp_ff.entry_site <= tk_q;
                  rsp_ff.entry_valid <= 1'b1;
               end
               rsp_tvalid <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   property p_busy_not_ready;
      @(posedge clock) disable iff (reset) (state_ff != S_IDLE) |-> !req_tready;
   endproperty
   a_busy: assert property (p_busy_not_ready) else $error("ready while busy");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= STACK_DEPTH) else $error("stack fill overflow");

   a_tfill: assert property (@(posedge clock) disable iff (reset)
      $countones(tvalid_ff) == 32'(tfill_ff)) else $error("table fill mismatch");

   a_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_PREP)) else $error("accept lost");
endmodule
`default_nettype wire
